// ===== rtl/sps_pkg.sv =====
// segment point sampler: shared types and fixed widths
// used by the interfaces, the arithmetic unit and the top level; no dependencies
package sps_pkg;

  // payload widths
  localparam int COORD_W  = 16;
  localparam int RADIUS_W = 15;

  // internal fixed widths
  localparam int DELTA_W = 17;  // end - start
  localparam int SQ_W    = 34;  // dx^2 + dy^2
  localparam int ROOT_W  = 17;  // segment length
  localparam int DIR_W   = 18;  // direction in Q.16, signed
  localparam int SUB_W   = 21;  // shared compare-subtract

  localparam int ONE_Q16  = 65536;
  localparam int HALF_Q16 = 32768;

  // compare-subtract request and answer
  typedef struct packed {
    logic [SUB_W-1:0] a;
    logic [SUB_W-1:0] b;
  } sub_req_t;

  typedef struct packed {
    logic [SUB_W-1:0] diff;
    logic             ge;
  } sub_rsp_t;

endpackage

// ===== rtl/sps_seg_if.sv =====
// segment channel: valid/ready handshake carrying one segment and radius
// depends on sps_pkg
interface sps_seg_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sps_pkg::COORD_W-1:0]    start_x;
  logic signed [sps_pkg::COORD_W-1:0]    start_y;
  logic signed [sps_pkg::COORD_W-1:0]    end_x;
  logic signed [sps_pkg::COORD_W-1:0]    end_y;
  logic        [sps_pkg::RADIUS_W-1:0]   radius;

  modport source (output valid, start_x, start_y, end_x, end_y, radius, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, radius, output ready);
endinterface

// ===== rtl/sps_pt_if.sv =====
// point channel: valid/ready handshake carrying one sampled point
// depends on sps_pkg
interface sps_pt_if;
  logic                                valid;
  logic                                ready;
  logic signed [sps_pkg::COORD_W-1:0]  point_x;
  logic signed [sps_pkg::COORD_W-1:0]  point_y;
  logic                                last_point;
  logic                                count_capped;

  modport source (output valid, point_x, point_y, last_point, count_capped, input ready);
  modport sink   (input valid, point_x, point_y, last_point, count_capped, output ready);
endinterface

// ===== rtl/segment_point_sampler.sv =====
// segment point sampler top level: sequencer, root, divide and point stepping
// depends on sps_pkg, sps_seg_if, sps_pt_if and sps_unit
//
//   port  dir  payload                                       handshake
//   seg   in   start_x, start_y, end_x, end_y, radius        valid/ready
//   pt    out  point_x, point_y, last_point, count_capped    valid/ready
//
// one segment at a time: the squares, the root, the two direction divides
// (skipped on a zero-length segment), the point-limit check, then for each
// point the x product, the y product and the output wait, all on the one
// multiplier and the one bit-per-cycle compare-subtract of sps_unit
// rst (synchronous) empties the sequencer and the output register
// a stalled output holds the sequencer at the point that waits; the next
// segment is taken while the final point still waits to be taken
module segment_point_sampler #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  sps_seg_if.sink    seg,
  sps_pt_if.source   pt
);

  localparam int K_W     = $clog2(MAX_POINTS);
  localparam int DIST_W  = $clog2(2 * MAX_POINTS) + sps_pkg::RADIUS_W;
  localparam int MA_W    = DIST_W + 1;
  localparam int MB_W    = sps_pkg::DIR_W;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int OFF_W   = PROD_W - 16;
  localparam int SUM_W   = (OFF_W + 1 > 33) ? OFF_W + 1 : 33;
  localparam int CAPK    = 2 * MAX_POINTS - 1;
  localparam int STEPS   = sps_pkg::ROOT_W - 1;

  localparam logic signed [SUM_W-1:0] CHI =
    SUM_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] CLO = -CHI - SUM_W'(1);
  localparam logic [K_W-1:0] K_LAST = K_W'(MAX_POINTS - 1);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MDX  = 4'd1;
  localparam logic [3:0] S_MDY  = 4'd2;
  localparam logic [3:0] S_MSUM = 4'd3;
  localparam logic [3:0] S_SQ   = 4'd4;
  localparam logic [3:0] S_DV   = 4'd5;
  localparam logic [3:0] S_CAPM = 4'd6;
  localparam logic [3:0] S_CAPC = 4'd7;
  localparam logic [3:0] S_PX   = 4'd8;
  localparam logic [3:0] S_PY   = 4'd9;
  localparam logic [3:0] S_PW   = 4'd10;

  logic [3:0] state;

  // segment registers
  logic signed [sps_pkg::COORD_W-1:0]  sx, sy;
  logic signed [sps_pkg::DELTA_W-1:0]  dx, dy;
  logic        [sps_pkg::RADIUS_W-1:0] r;

  // root and divide registers
  logic [sps_pkg::SQ_W-1:0]    sumsq;
  logic [sps_pkg::SQ_W-1:0]    rad;
  logic [18:0]                 rem;
  logic [sps_pkg::ROOT_W-1:0]  quo;
  logic [sps_pkg::ROOT_W-1:0]  d;
  logic [4:0]                  cnt;
  logic                        div_y;
  logic signed [sps_pkg::DIR_W-1:0] ux, uy;

  // point stepping
  logic              capped;
  logic [DIST_W-1:0] span;
  logic [K_W-1:0]    k;
  logic [15:0]       px_sat;

  // output register
  logic        ovalid;
  logic [15:0] ox, oy;
  logic        olast, ocap;

  // shared unit connections
  logic                     mul_load;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod;
  sps_pkg::sub_req_t        req;
  sps_pkg::sub_rsp_t        rsp;

  sps_unit #(
    .MA_W (MA_W),
    .MB_W (MB_W)
  ) u_unit (
    .clk      (clk),
    .mul_load (mul_load),
    .mul_a    (mul_a),
    .mul_b    (mul_b),
    .prod     (prod),
    .req      (req),
    .rsp      (rsp)
  );

  // magnitudes of the deltas for the divide
  logic [sps_pkg::DELTA_W-1:0] dx_mag, dy_mag, mag;
  logic                        nbit;
  assign dx_mag = dx[sps_pkg::DELTA_W-1] ? sps_pkg::DELTA_W'(-dx) : dx;
  assign dy_mag = dy[sps_pkg::DELTA_W-1] ? sps_pkg::DELTA_W'(-dy) : dy;
  assign mag    = div_y ? dy_mag : dx_mag;
  assign nbit   = (cnt == 5'(STEPS)) ? mag[0] : 1'b0;

  // signed quotient once the last bit is in
  logic [sps_pkg::ROOT_W-1:0]       quo_next;
  logic signed [sps_pkg::DIR_W-1:0] dir_mag, dir_val;
  logic                             dir_neg;
  assign quo_next = {quo[sps_pkg::ROOT_W-2:0], rsp.ge};
  assign dir_mag  = sps_pkg::DIR_W'({1'b0, quo_next});
  assign dir_neg  = div_y ? dy[sps_pkg::DELTA_W-1] : dx[sps_pkg::DELTA_W-1];
  assign dir_val  = dir_neg ? -dir_mag : dir_mag;

  // rounded offset from the product, added to the start and saturated
  logic signed [PROD_W-1:0]          prod_rnd;
  logic signed [OFF_W-1:0]           off;
  logic signed [sps_pkg::COORD_W-1:0] base;
  logic signed [SUM_W-1:0]           coord_sum;
  logic [15:0]                       coord_sat;
  always_comb begin
    prod_rnd = prod + PROD_W'(sps_pkg::HALF_Q16);
    off      = prod_rnd[PROD_W-1:16];
    base     = (state == S_PY) ? sx : sy;
    coord_sum = {{(SUM_W - sps_pkg::COORD_W){base[sps_pkg::COORD_W-1]}}, base}
              + {{(SUM_W - OFF_W){off[OFF_W-1]}}, off};
    if (coord_sum > CHI) begin
      coord_sat = CHI[15:0];
    end else if (coord_sum < CLO) begin
      coord_sat = CLO[15:0];
    end else begin
      coord_sat = coord_sum[15:0];
    end
  end

  // operand selection for the shared unit
  always_comb begin
    mul_load = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    req.a    = '0;
    req.b    = '0;
    case (state)
      S_MDX: begin
        mul_load = 1'b1;
        mul_a    = {{(MA_W - sps_pkg::DELTA_W){dx[sps_pkg::DELTA_W-1]}}, dx};
        mul_b    = {{(MB_W - sps_pkg::DELTA_W){dx[sps_pkg::DELTA_W-1]}}, dx};
      end
      S_MDY: begin
        mul_load = 1'b1;
        mul_a    = {{(MA_W - sps_pkg::DELTA_W){dy[sps_pkg::DELTA_W-1]}}, dy};
        mul_b    = {{(MB_W - sps_pkg::DELTA_W){dy[sps_pkg::DELTA_W-1]}}, dy};
      end
      S_SQ: begin
        req.a = {rem, rad[sps_pkg::SQ_W-1:sps_pkg::SQ_W-2]};
        req.b = sps_pkg::SUB_W'({quo, 2'b01});
      end
      S_DV: begin
        req.a = sps_pkg::SUB_W'({rem[16:0], nbit});
        req.b = sps_pkg::SUB_W'(d);
      end
      S_CAPM: begin
        mul_load = 1'b1;
        mul_a    = MA_W'(r);
        mul_b    = MB_W'(CAPK);
      end
      S_PX: begin
        mul_load = 1'b1;
        mul_a    = {1'b0, span};
        mul_b    = ux;
      end
      S_PY: begin
        mul_load = 1'b1;
        mul_a    = {1'b0, span};
        mul_b    = uy;
      end
      default: begin
        mul_load = 1'b0;
      end
    endcase
  end

  // output register free to take a point
  logic out_free, is_last;
  assign out_free = !ovalid || pt.ready;
  assign is_last  = (span >= DIST_W'(d)) || (k == K_LAST);

  assign seg.ready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (seg.valid) begin
            state <= S_MDX;
          end
        end
        S_MDX:  state <= S_MDY;
        S_MDY:  state <= S_MSUM;
        S_MSUM: state <= S_SQ;
        S_SQ: begin
          if (cnt == 5'd0) begin
            state <= (quo_next == '0) ? S_CAPM : S_DV;
          end
        end
        S_DV: begin
          if (cnt == 5'd0 && div_y) begin
            state <= S_CAPM;
          end
        end
        S_CAPM: state <= S_CAPC;
        S_CAPC: state <= S_PX;
        S_PX:   state <= S_PY;
        S_PY:   state <= S_PW;
        S_PW: begin
          if (out_free) begin
            state <= is_last ? S_IDLE : S_PX;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (seg.valid) begin
          sx <= seg.start_x;
          sy <= seg.start_y;
          dx <= {seg.end_x[15], seg.end_x} - {seg.start_x[15], seg.start_x};
          dy <= {seg.end_y[15], seg.end_y} - {seg.start_y[15], seg.start_y};
          r  <= seg.radius;
        end
      end
      S_MDY: begin
        sumsq <= prod[sps_pkg::SQ_W-1:0];
      end
      S_MSUM: begin
        rad <= sumsq + prod[sps_pkg::SQ_W-1:0];
        rem <= '0;
        quo <= '0;
        cnt <= 5'(STEPS);
      end
      S_SQ: begin
        rad <= rad << 2;
        if (cnt != 5'd0) begin
          rem <= rsp.ge ? rsp.diff[18:0] : req.a[18:0];
          quo <= quo_next;
          cnt <= cnt - 5'd1;
        end else begin
          d <= quo_next;
          if (quo_next == '0) begin
            // zero length: direction along x
            ux <= sps_pkg::DIR_W'(sps_pkg::ONE_Q16);
            uy <= '0;
          end else begin
            div_y <= 1'b0;
            rem   <= {3'b000, dx_mag[16:1]};
            quo   <= '0;
            cnt   <= 5'(STEPS);
          end
        end
      end
      S_DV: begin
        if (cnt != 5'd0) begin
          rem <= rsp.ge ? rsp.diff[18:0] : req.a[18:0];
          quo <= quo_next;
          cnt <= cnt - 5'd1;
        end else if (!div_y) begin
          ux    <= dir_val;
          div_y <= 1'b1;
          rem   <= {3'b000, dy_mag[16:1]};
          quo   <= '0;
          cnt   <= 5'(STEPS);
        end else begin
          uy <= dir_val;
        end
      end
      S_CAPC: begin
        capped <= ($unsigned(prod) < PROD_W'(d));
        span   <= DIST_W'(r);
        k      <= '0;
      end
      S_PY: begin
        px_sat <= coord_sat;
      end
      S_PW: begin
        if (out_free && !is_last) begin
          span <= span + DIST_W'({r, 1'b0});
          k    <= k + K_W'(1);
        end
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (state == S_PW && out_free) begin
      ovalid <= 1'b1;
    end else if (pt.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PW && out_free) begin
      ox    <= px_sat;
      oy    <= coord_sat;
      olast <= is_last;
      ocap  <= capped;
    end
  end

  assign pt.valid        = ovalid;
  assign pt.point_x      = ox;
  assign pt.point_y      = oy;
  assign pt.last_point   = olast;
  assign pt.count_capped = ocap;

endmodule

// ===== rtl/sps_unit.sv =====
// shared arithmetic unit: registered signed multiplier and combinational compare-subtract
// depends on sps_pkg
module sps_unit #(
  parameter int MA_W = 23,
  parameter int MB_W = 18
) (
  input  logic                          clk,
  input  logic                          mul_load,
  input  logic signed [MA_W-1:0]        mul_a,
  input  logic signed [MB_W-1:0]        mul_b,
  output logic signed [MA_W+MB_W-1:0]   prod,
  input  sps_pkg::sub_req_t             req,
  output sps_pkg::sub_rsp_t             rsp
);

  // product register, held while no new product is requested
  always_ff @(posedge clk) begin
    if (mul_load) begin
      prod <= mul_a * mul_b;
    end
  end

  // one compare-subtract, used a bit per cycle by root and divide
  always_comb begin
    rsp.diff = req.a - req.b;
    rsp.ge   = (req.a >= req.b);
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// testbench for segment_point_sampler: segments in on seg, sampled points out on pt
// depends on sps_pkg, sps_seg_if, sps_pt_if and the segment_point_sampler rtl
module testbench;

  localparam int COORD_W      = sps_pkg::COORD_W;
  localparam int RADIUS_W     = sps_pkg::RADIUS_W;
  localparam int ONE_Q16      = sps_pkg::ONE_Q16;
  localparam int HALF_Q16     = sps_pkg::HALF_Q16;

  localparam int MAX_POINTS   = 64;
  localparam int COORD_BITS   = 16;
  localparam int RANDOM_ITEMS = 200;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES  = 400;

  typedef struct {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic [RADIUS_W-1:0]       radius;
  } segment_t;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
    logic                      capped;
  } point_t;

  // directed row: segment, then either a typed result (n copies of one point)
  // or zero in typed, meaning the row goes through the predictor
  typedef struct {
    int sx, sy, ex, ey, r;
    bit typed;
    int n;
    int px, py;
    bit capped;
  } stim_row_t;

  localparam int NUM_ROWS = 22;

  stim_row_t directed_rows [NUM_ROWS] = '{
    // zero-length segments: one point at start + (radius, 0)
    '{0, 0, 0, 0, 256,                        1, 1, 256, 0, 0},
    '{32767, -32768, 32767, -32768, 32767,    1, 1, 32767, -32768, 0},
    '{-32768, 100, -32768, 100, 1,            1, 1, -32767, 100, 0},
    '{100, -50, 100, -50, 32767,              1, 1, 32767, -50, 0},
    // radius zero: every point sits on the start
    '{1234, -77, 1234, -77, 0,                1, 1, 1234, -77, 0},
    '{0, 0, 256, 0, 0,                        1, 64, 0, 0, 1},
    '{-32768, 32767, 32767, -32768, 0,        1, 64, -32768, 32767, 1},
    // full-range diagonals, both directions
    '{-32768, -32768, 32767, 32767, 32767,    0, 0, 0, 0, 0},
    '{-32768, -32768, 32767, 32767, 1,        0, 0, 0, 0, 0},
    '{32767, 32767, -32768, -32768, 32767,    0, 0, 0, 0, 0},
    // axis-aligned runs
    '{0, 0, 2560, 0, 256,                     0, 0, 0, 0, 0},
    '{0, 0, 0, -2560, 128,                    0, 0, 0, 0, 0},
    '{-32768, 0, 32767, 0, 512,               0, 0, 0, 0, 0},
    '{0, -32768, 0, 32767, 16384,             0, 0, 0, 0, 0},
    // segment shorter than the radius, and an exact multiple
    '{0, 0, 10, 0, 100,                       0, 0, 0, 0, 0},
    '{0, 0, 1024, 0, 256,                     0, 0, 0, 0, 0},
    // point limit: just fits, then one unit over
    '{0, 0, 127, 0, 1,                        0, 0, 0, 0, 0},
    '{0, 0, 128, 0, 1,                        0, 0, 0, 0, 0},
    // runs that overshoot the coordinate range
    '{32000, 32000, 32767, 32767, 4096,       0, 0, 0, 0, 0},
    '{-32000, 0, -32768, 0, 8000,             0, 0, 0, 0, 0},
    // 3-4-5 directions, truncated direction and rounding of offsets
    '{0, 0, 768, 1024, 256,                   0, 0, 0, 0, 0},
    '{-300, -300, -1068, -1324, 128,          0, 0, 0, 0, 0}
  };

  logic clk;
  logic rst;

  sps_seg_if seg_ch ();
  sps_pt_if  pt_ch ();

  segment_point_sampler #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .seg (seg_ch),
    .pt  (pt_ch)
  );

  point_t pending_points[$];
  int     mismatches;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 50) $display("MISMATCH: %s", what);
  endtask

  // queue one expected point at the back
  function automatic void expect_point(input point_t p);
    pending_points.insert(pending_points.size(), p);
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
    longint top, bottom;
    top    = (longint'(1) << (COORD_BITS - 1)) - 1;
    bottom = -top - 1;
    if (v > top) v = top;
    else if (v < bottom) v = bottom;
    return COORD_W'(v);
  endfunction

  // floor square root, one result bit at a time from the top
  function automatic longint int_sqrt(input longint v);
    longint root, trial;
    root = 0;
    for (int b = 17; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // expected points of one segment, appended to pending_points
  function automatic void sample_segment(input segment_t s);
    longint dx, dy, len, ux, uy, reach, span, rad;
    int     count;
    bit     capped;
    point_t p;
    dx  = longint'(s.end_x) - longint'(s.start_x);
    dy  = longint'(s.end_y) - longint'(s.start_y);
    rad = longint'(s.radius);
    len = int_sqrt(dx * dx + dy * dy);
    if (len == 0) begin
      ux = ONE_Q16;
      uy = 0;
    end else begin
      ux = (dx * ONE_Q16) / len;
      uy = (dy * ONE_Q16) / len;
    end
    // number of points: grow by one spacing while still short of the end
    reach  = rad;
    count  = 1;
    capped = 1'b0;
    while (reach < len) begin
      if (count >= MAX_POINTS) begin
        capped = 1'b1;
        break;
      end
      count++;
      reach += 2 * rad;
    end
    // each point straight from the start, offset rounded half up
    for (int k = 0; k < count; k++) begin
      span     = longint'(2 * k + 1) * rad;
      p.x      = clamp_coord(longint'(s.start_x) + ((span * ux + HALF_Q16) >>> 16));
      p.y      = clamp_coord(longint'(s.start_y) + ((span * uy + HALF_Q16) >>> 16));
      p.last   = (k == count - 1);
      p.capped = capped;
      expect_point(p);
    end
  endfunction

  // gap length: mostly none, some short, a few long
  function automatic int idle_span();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [COORD_W-1:0] rim_coord();
    case ($urandom_range(0, 4))
      0:       return -32768;
      1:       return -32767;
      2:       return 32766;
      3:       return 32767;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic segment_t random_segment();
    segment_t s;
    int       shape;
    shape     = $urandom_range(0, 99);
    s.start_x = COORD_W'($urandom);
    s.start_y = COORD_W'($urandom);
    s.end_x   = COORD_W'($urandom);
    s.end_y   = COORD_W'($urandom);
    s.radius  = RADIUS_W'($urandom_range(1, 32767));
    if (shape < 40) begin
      // short segment with a modest radius: a handful of points
      s.end_x  = clamp_coord(longint'(s.start_x) + $urandom_range(0, 4096) - 2048);
      s.end_y  = clamp_coord(longint'(s.start_y) + $urandom_range(0, 4096) - 2048);
      s.radius = RADIUS_W'($urandom_range(1, 512));
    end else if (shape < 55) begin
      // long segment, tiny radius: cut at the point limit
      s.radius = RADIUS_W'($urandom_range(1, 64));
    end else if (shape < 65) begin
      s.end_x = s.start_x;
      s.end_y = s.start_y;
    end else if (shape < 80) begin
      // near the corners of the range, for saturation
      s.start_x = rim_coord();
      s.start_y = rim_coord();
      s.end_x   = rim_coord();
      s.end_y   = rim_coord();
    end
    return s;
  endfunction

  task automatic send_segment(input segment_t s, input bit calm);
    int gap;
    gap = calm ? 0 : idle_span();
    if (gap > 0) begin
      seg_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    seg_ch.valid   <= 1'b1;
    seg_ch.start_x <= s.start_x;
    seg_ch.start_y <= s.start_y;
    seg_ch.end_x   <= s.end_x;
    seg_ch.end_y   <= s.end_y;
    seg_ch.radius  <= s.radius;
    do @(posedge clk); while (seg_ch.ready !== 1'b1);
  endtask

  // point receiver: check each accepted item, then choose ready for the next cycle
  initial begin
    point_t want;
    int     taken;
    int     stall_left;
    int     hold_left;
    int     cycle_no;
    bit     idle_on;
    taken      = 0;
    stall_left = 0;
    hold_left  = 0;
    cycle_no   = 0;
    idle_on    = 1'b1;
    pt_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cycle_no++;
      if (!rst && pt_ch.valid === 1'b1 && pt_ch.ready === 1'b1) begin
        if (pending_points.size() == 0) begin
          flag_mismatch($sformatf("point (%0d,%0d) last=%0b capped=%0b with nothing expected",
                                  pt_ch.point_x, pt_ch.point_y, pt_ch.last_point,
                                  pt_ch.count_capped));
        end else begin
          want = pending_points.pop_front();
          if (pt_ch.point_x !== want.x || pt_ch.point_y !== want.y ||
              pt_ch.last_point !== want.last || pt_ch.count_capped !== want.capped)
            flag_mismatch($sformatf(
              "point %0d: got (%0d,%0d) last=%0b capped=%0b, want (%0d,%0d) last=%0b capped=%0b",
              taken, pt_ch.point_x, pt_ch.point_y, pt_ch.last_point, pt_ch.count_capped,
              want.x, want.y, want.last, want.capped));
        end
        taken++;
        // long hold-off so the block fills up and stalls its input
        if (taken == 200 || taken == 1500) hold_left = HOLD_CYCLES;
      end
      // idling switched off now and then for stretches
      if (cycle_no % 256 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (hold_left > 0) begin
        hold_left--;
        pt_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pt_ch.ready <= 1'b0;
      end else begin
        pt_ch.ready <= 1'b1;
        if (idle_on) stall_left = idle_span();
      end
    end
  end

  // watchdog: too long with no item moving on either channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((seg_ch.valid === 1'b1 && seg_ch.ready === 1'b1) ||
          (pt_ch.valid === 1'b1 && pt_ch.ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // segment sender: reset, directed table, random items, drain
  initial begin
    segment_t  cur;
    stim_row_t row;
    bit        calm;
    point_t    typed_pt;
    mismatches = 0;
    rst            <= 1'b1;
    seg_ch.valid   <= 1'b0;
    seg_ch.start_x <= '0;
    seg_ch.start_y <= '0;
    seg_ch.end_x   <= '0;
    seg_ch.end_y   <= '0;
    seg_ch.radius  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed part
    for (int i = 0; i < NUM_ROWS; i++) begin
      row         = directed_rows[i];
      cur.start_x = COORD_W'(row.sx);
      cur.start_y = COORD_W'(row.sy);
      cur.end_x   = COORD_W'(row.ex);
      cur.end_y   = COORD_W'(row.ey);
      cur.radius  = RADIUS_W'(row.r);
      send_segment(cur, 1'b0);
      if (row.typed) begin
        for (int k = 0; k < row.n; k++) begin
          typed_pt.x      = COORD_W'(row.px);
          typed_pt.y      = COORD_W'(row.py);
          typed_pt.last   = (k == row.n - 1);
          typed_pt.capped = row.capped;
          expect_point(typed_pt);
        end
      end else begin
        sample_segment(cur);
      end
    end

    // sender pause until every point so far has come out
    seg_ch.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);

    // random part
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) begin
        seg_ch.valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge clk);
      end
      calm = ((i / 25) % 4 == 3);
      cur  = random_segment();
      send_segment(cur, calm);
      sample_segment(cur);
    end

    // drain
    seg_ch.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_points.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
